// ===== hdl/pil_pkg.sv =====
// ----------------------------------------------------------------------------
// pil_pkg
// Shared sizes, codes and bundles for the position indexed list.
// ----------------------------------------------------------------------------
package pil_pkg;

  localparam int DEPTH      = 64;
  localparam int WORD_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int LEN_W      = 7;
  localparam int CMD_W      = 2;
  localparam int POS_W      = 8;
  localparam int STATUS_W   = 2;

  localparam logic [LEN_W-1:0] CAPACITY_RESET = LEN_W'(DEPTH);

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [WORD_WIDTH-1:0] read_value;
    logic [LEN_W-1:0]      length;
  } result_t;

endpackage

// ===== hdl/pil_mem.sv =====
// ----------------------------------------------------------------------------
// pil_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pil_mem (
  input  logic                           clk,
  input  pil_pkg::mem_req_t              req,
  output logic [pil_pkg::WORD_WIDTH-1:0] rd_data
);

  logic [pil_pkg::WORD_WIDTH-1:0] mem [pil_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== hdl/pil_ctrl.sv =====
// ----------------------------------------------------------------------------
// pil_ctrl
// Sequencer: decodes a command, then walks one index counter through the
// entry store, moving one entry per cycle through the memory read/write path.
// ----------------------------------------------------------------------------
module pil_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_take,
  input  logic [pil_pkg::CMD_W-1:0]      cmd,
  input  logic [pil_pkg::POS_W-1:0]      position,
  input  logic [pil_pkg::WORD_WIDTH-1:0] value,
  input  logic [pil_pkg::LEN_W-1:0]      capacity,
  input  logic                           slot_free,
  output logic                           busy,
  output logic                           res_load,
  output pil_pkg::result_t               res,
  output pil_pkg::mem_req_t              mem_req,
  input  logic [pil_pkg::WORD_WIDTH-1:0] mem_rdata
);

  localparam logic [pil_pkg::LEN_W-1:0] DEPTH_LEN = pil_pkg::LEN_W'(pil_pkg::DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UP   = 5'b00010,
    S_PUT  = 5'b00100,
    S_DOWN = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                         state, state_next;
  logic [pil_pkg::LEN_W-1:0]      count, count_next;
  logic                           pend, pend_next;
  logic                           cap, cap_next;
  logic                           del, del_next;
  logic [pil_pkg::LEN_W-1:0]      idx, idx_next;
  logic [pil_pkg::ADDR_W-1:0]     pos, pos_next;
  logic [pil_pkg::ADDR_W-1:0]     wr_addr, wr_addr_next;
  logic [pil_pkg::WORD_WIDTH-1:0] wval, wval_next;
  logic [pil_pkg::WORD_WIDTH-1:0] rd, rd_next;
  logic [pil_pkg::STATUS_W-1:0]   status, status_next;

  logic                       negative;
  logic [pil_pkg::LEN_W-1:0]  pos7;
  logic [pil_pkg::LEN_W-1:0]  clamped;
  logic [pil_pkg::LEN_W-1:0]  idx_dec;
  logic [pil_pkg::LEN_W-1:0]  idx_inc;
  logic                       full;
  logic                       out_of_range;

  assign negative     = position[pil_pkg::POS_W-1];
  assign pos7         = position[pil_pkg::LEN_W-1:0];
  assign clamped      = (pos7 > count) ? count : pos7;
  assign idx_dec      = idx - 1'b1;
  assign idx_inc      = idx + 1'b1;
  assign full         = (count >= capacity) || (count >= DEPTH_LEN);
  assign out_of_range = (pos7 >= count);

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    count_next   = count;
    pend_next    = 1'b0;
    cap_next     = 1'b0;
    del_next     = del;
    idx_next     = idx;
    pos_next     = pos;
    wr_addr_next = wr_addr;
    wval_next    = wval;
    rd_next      = rd;
    status_next  = status;
    res_load     = 1'b0;

    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = wr_addr;
    mem_req.wr_data = mem_rdata;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = idx[pil_pkg::ADDR_W-1:0];

    case (state)
      S_IDLE: begin
        if (in_take) begin
          rd_next     = '0;
          status_next = pil_pkg::ST_OK;
          wval_next   = value;
          del_next    = (cmd == pil_pkg::CMD_DELETE);
          if (negative) begin
            status_next = pil_pkg::ST_BAD_POS;
            state_next  = S_DONE;
          end else begin
            case (cmd)
              pil_pkg::CMD_INSERT: begin
                if (full) begin
                  status_next = pil_pkg::ST_FULL;
                  state_next  = S_DONE;
                end else begin
                  pos_next   = clamped[pil_pkg::ADDR_W-1:0];
                  idx_next   = count;
                  state_next = S_UP;
                end
              end
              pil_pkg::CMD_GET, pil_pkg::CMD_DELETE: begin
                if (out_of_range) begin
                  status_next = pil_pkg::ST_BAD_POS;
                  state_next  = S_DONE;
                end else begin
                  // fetch the addressed entry, the shift starts just above it
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = pos7[pil_pkg::ADDR_W-1:0];
                  cap_next        = 1'b1;
                  idx_next        = pos7 + 1'b1;
                  state_next      = S_DOWN;
                end
              end
              default: begin
                status_next = pil_pkg::ST_BAD_POS;
                state_next  = S_DONE;
              end
            endcase
          end
        end
      end
      S_UP: begin
        mem_req.wr_en = pend;
        if (idx > {1'b0, pos}) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_dec[pil_pkg::ADDR_W-1:0];
          pend_next       = 1'b1;
          wr_addr_next    = idx[pil_pkg::ADDR_W-1:0];
          idx_next        = idx_dec;
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos;
        mem_req.wr_data = wval;
        count_next      = count + 1'b1;
        state_next      = S_DONE;
      end
      S_DOWN: begin
        mem_req.wr_en = pend;
        if (cap) begin
          rd_next = mem_rdata;
        end
        if (del && (idx < count)) begin
          mem_req.rd_en = 1'b1;
          pend_next     = 1'b1;
          wr_addr_next  = idx_dec[pil_pkg::ADDR_W-1:0];
          idx_next      = idx_inc;
        end else begin
          if (del) begin
            count_next = count - 1'b1;
          end
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res.status     = status;
  assign res.read_value = rd;
  assign res.length     = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      cap   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      cap   <= cap_next;
    end
  end

  always_ff @(posedge clk) begin
    del     <= del_next;
    idx     <= idx_next;
    pos     <= pos_next;
    wr_addr <= wr_addr_next;
    wval    <= wval_next;
    rd      <= rd_next;
    status  <= status_next;
  end

  // length never passes the store depth
  assert property (@(posedge clk) disable iff (rst) count <= DEPTH_LEN)
    else $error("entry count beyond depth");

  // the shift never reads and writes the same entry in one cycle
  assert property (@(posedge clk) disable iff (rst)
    (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
    else $error("read and write collide in entry store");

  // length moves by at most one per item
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |->
      ((count == $past(count) + 1'b1) || (count + 1'b1 == $past(count))))
    else $error("entry count jumped");

  // a new item is only taken while the sequencer is idle
  assert property (@(posedge clk) disable iff (rst) in_take |-> (state == S_IDLE))
    else $error("item taken while busy");

endmodule

// ===== hdl/position_indexed_list.sv =====
// ----------------------------------------------------------------------------
// position_indexed_list
// Ordered list of words with insert, get and delete by position.
// ----------------------------------------------------------------------------
// One command word in, one result word out. The block holds one command at a
// time: in_stall is high from the cycle after a command is taken until its
// result has been handed to the output register. A command that fails
// (negative position, position past the length on a get or delete, unused
// command code, insert into a full list) goes straight to its result. An
// insert at position p moves the entries from p upward up one place, and a
// delete moves the entries above p down one place, one per cycle through the
// single read and single write port of the entry memory. The result register
// lets the next command be taken while a result still waits for the
// downstream side. The list capacity register is written on its own
// valid/ready port while no command is in flight; values above the store
// depth act as the depth, zero makes the list always full. Reset empties the
// list; no clearing pass is needed.
// ----------------------------------------------------------------------------
module position_indexed_list (
  input  logic                             clk,
  input  logic                             rst,
  // command channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pil_pkg::CMD_W-1:0]        cmd,
  input  logic signed [pil_pkg::POS_W-1:0] position,
  input  logic [pil_pkg::WORD_WIDTH-1:0]   value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pil_pkg::STATUS_W-1:0]     status,
  output logic [pil_pkg::WORD_WIDTH-1:0]   read_value,
  output logic [pil_pkg::LEN_W-1:0]        length,
  // capacity register write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pil_pkg::LEN_W-1:0]        cfg_data
);

  logic                           busy;
  logic                           in_take;
  logic                           slot_free;
  logic                           res_load;
  pil_pkg::result_t               res;
  pil_pkg::result_t               res_out;
  pil_pkg::mem_req_t              mem_req;
  logic [pil_pkg::WORD_WIDTH-1:0] mem_rdata;
  logic [pil_pkg::LEN_W-1:0]      list_capacity;

  // sequencer owns the list, so stall whenever it is working
  assign in_stall  = busy;
  assign in_take   = in_valid && !busy;
  assign cfg_ready = !busy;

  // output register can take a word when empty or being drained
  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_capacity <= pil_pkg::CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      list_capacity <= cfg_data;
    end
  end

  pil_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .cmd       (cmd),
    .position  (position),
    .value     (value),
    .capacity  (list_capacity),
    .slot_free (slot_free),
    .busy      (busy),
    .res_load  (res_load),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  pil_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rdata)
  );

  // result register, valid cleared once the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_out <= res;
    end
  end

  assign status     = res_out.status;
  assign read_value = res_out.read_value;
  assign length     = res_out.length;

endmodule
